@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, command codes and types of the Q17.14 fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS = 14;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 4;
    localparam int DVD_W     = WORD_W + FRAC_BITS;

    localparam logic [CMD_W-1:0] CMD_ITOF    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_FTOI    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ADD     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SUB     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_ADD_INT = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SUB_INT = 4'd5;
    localparam logic [CMD_W-1:0] CMD_MUL     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MUL_INT = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DIV     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_DIV_INT = 4'd9;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              is_div;
        logic              is_mul;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } item_t;

endpackage

@@ rtl/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// Accepts requests from the input stream and classifies the command.
// ----------------------------------------------------------------------------
module fpa_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*fpa_pkg::WORD_W-1:0]  s_tdata,
    input  logic [fpa_pkg::CMD_W-1:0]     s_tuser,
    output logic                          push_valid,
    input  logic                          push_ready,
    output fpa_pkg::item_t                push_item
);

    logic           valid_reg;
    logic           valid_next;
    fpa_pkg::item_t item_reg;
    fpa_pkg::item_t item_next;
    logic           accept;

    assign s_tready   = !valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        valid_next       = accept || (valid_reg && !push_ready);
        item_next.cmd    = s_tuser;
        item_next.is_div = (s_tuser == fpa_pkg::CMD_DIV) || (s_tuser == fpa_pkg::CMD_DIV_INT);
        item_next.is_mul = (s_tuser == fpa_pkg::CMD_MUL) || (s_tuser == fpa_pkg::CMD_MUL_INT);
        item_next.a      = s_tdata[fpa_pkg::WORD_W-1:0];
        item_next.b      = s_tdata[2*fpa_pkg::WORD_W-1:fpa_pkg::WORD_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/fpa_queue.sv @@
// ----------------------------------------------------------------------------
// fpa_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module fpa_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  fpa_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output fpa_pkg::item_t out_item
);

    fpa_pkg::item_t mem [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: adder, multiplier, bit-per-stage divider, output reg.
// ----------------------------------------------------------------------------
module fpa_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fpa_pkg::item_t              in_item,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fpa_pkg::WORD_W-1:0]  m_tdata,
    output logic                        m_tuser
);

    localparam int W  = fpa_pkg::WORD_W;
    localparam int F  = fpa_pkg::FRAC_BITS;
    localparam int DW = fpa_pkg::DVD_W;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign in_ready = en;

    // first stage: simple ops, product, divider setup
    logic                 s1_valid_reg;
    logic [fpa_pkg::CMD_W-1:0] s1_cmd_reg;
    logic                 s1_is_div_reg;
    logic [W-1:0]         s1_res_reg;
    logic [2*W-1:0]       s1_prod_reg;
    logic [DW-1:0]        s1_dvd_reg;
    logic [W-1:0]         s1_dsr_reg;
    logic                 s1_neg_reg;
    logic                 s1_dz_reg;

    logic [W-1:0]  a;
    logic [W-1:0]  b;
    logic [W-1:0]  bsh;
    logic [W-1:0]  ftoi_adj;
    logic [W-1:0]  a_mag;
    logic [W-1:0]  res_next;
    logic [DW-1:0] dvd_next;

    always_comb begin
        a        = in_item.a;
        b        = in_item.b;
        bsh      = b << F;
        ftoi_adj = a + (a[W-1] ? W'((1 << F) - 1) : W'(0));
        a_mag    = a[W-1] ? (~a + W'(1)) : a;
        case (in_item.cmd)
            fpa_pkg::CMD_ITOF:    res_next = bsh;
            fpa_pkg::CMD_FTOI:    res_next = W'($signed(ftoi_adj) >>> F);
            fpa_pkg::CMD_ADD:     res_next = a + b;
            fpa_pkg::CMD_SUB:     res_next = a - b;
            fpa_pkg::CMD_ADD_INT: res_next = a + bsh;
            fpa_pkg::CMD_SUB_INT: res_next = a - bsh;
            default:              res_next = '0;
        endcase
        if (in_item.cmd == fpa_pkg::CMD_DIV) begin
            dvd_next = {a_mag, {F{1'b0}}};
        end else begin
            dvd_next = {{F{1'b0}}, a_mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
        if (en) begin
            s1_cmd_reg    <= in_item.cmd;
            s1_is_div_reg <= in_item.is_div;
            s1_res_reg    <= res_next;
            s1_prod_reg   <= (in_item.is_mul) ? 64'($signed(a) * $signed(b)) : '0;
            s1_dvd_reg    <= dvd_next;
            s1_dsr_reg    <= b[W-1] ? (~b + W'(1)) : b;
            s1_neg_reg    <= a[W-1] ^ b[W-1];
            s1_dz_reg     <= in_item.is_div && (b == '0);
        end
    end

    // divider chain; side fields travel along
    logic          d_valid_reg  [0:DW];
    logic          d_is_div_reg [0:DW];
    logic          d_neg_reg    [0:DW];
    logic          d_dz_reg     [0:DW];
    logic [W-1:0]  d_res_reg    [0:DW];
    logic [W-1:0]  d_rem_reg    [0:DW];
    logic [DW-1:0] d_dvd_reg    [0:DW];
    logic [W-1:0]  d_dsr_reg    [0:DW];

    logic [2*W-1:0] prod_adj;
    logic [W-1:0]   s1_res_final;

    always_comb begin
        prod_adj = s1_prod_reg + (s1_prod_reg[2*W-1] ? (2*W)'((1 << F) - 1) : (2*W)'(0));
        case (s1_cmd_reg)
            fpa_pkg::CMD_MUL:     s1_res_final = prod_adj[F+W-1:F];
            fpa_pkg::CMD_MUL_INT: s1_res_final = s1_prod_reg[W-1:0];
            default:              s1_res_final = s1_res_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg[0] <= 1'b0;
        end else if (en) begin
            d_valid_reg[0] <= s1_valid_reg;
        end
        if (en) begin
            d_is_div_reg[0] <= s1_is_div_reg;
            d_neg_reg[0]    <= s1_neg_reg;
            d_dz_reg[0]     <= s1_dz_reg;
            d_res_reg[0]    <= s1_res_final;
            d_rem_reg[0]    <= '0;
            d_dvd_reg[0]    <= s1_dvd_reg;
            d_dsr_reg[0]    <= s1_dsr_reg;
        end
    end

    for (genvar k = 0; k < DW; k++) begin : g_div
        logic [W:0]   trial;
        logic         ge;
        logic [W:0]   diff;

        always_comb begin
            trial = {d_rem_reg[k], d_dvd_reg[k][DW-1]};
            ge    = (trial >= {1'b0, d_dsr_reg[k]});
            diff  = trial - {1'b0, d_dsr_reg[k]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                d_valid_reg[k+1] <= d_valid_reg[k];
            end
            if (en) begin
                d_is_div_reg[k+1] <= d_is_div_reg[k];
                d_neg_reg[k+1]    <= d_neg_reg[k];
                d_dz_reg[k+1]     <= d_dz_reg[k];
                d_res_reg[k+1]    <= d_res_reg[k];
                d_dsr_reg[k+1]    <= d_dsr_reg[k];
                d_rem_reg[k+1]    <= ge ? diff[W-1:0] : trial[W-1:0];
                d_dvd_reg[k+1]    <= {d_dvd_reg[k][DW-2:0], ge};
            end
        end
    end

    // output register
    logic         out_valid_reg;
    logic [W-1:0] out_data_reg;
    logic         out_dz_reg;
    logic [W-1:0] quot;
    logic [W-1:0] fin;

    always_comb begin
        quot = d_dvd_reg[DW][W-1:0];
        if (d_dz_reg[DW]) begin
            fin = '0;
        end else if (d_is_div_reg[DW]) begin
            fin = d_neg_reg[DW] ? (~quot + W'(1)) : quot;
        end else begin
            fin = d_res_reg[DW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d_valid_reg[DW];
        end
        if (en) begin
            out_data_reg <= fin;
            out_dz_reg   <= d_dz_reg[DW];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_dz_reg;

endmodule

@@ rtl/fixed_point_q17_14_alu_core.sv @@
// ----------------------------------------------------------------------------
// fixed_point_q17_14_alu_core
// Requests pass the front register, the two-entry queue, the first stage, the
// divider (one quotient bit per stage) and the output register.
// Throughput: one request per cycle, for every command, while m_tready does not stall the output.
// Reset: aresetn clears all valid bits; pipeline data is not reset.
// ----------------------------------------------------------------------------
module fixed_point_q17_14_alu_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*fpa_pkg::WORD_W-1:0]        s_tdata,  // operand_a, operand_b
    input  logic [fpa_pkg::CMD_W-1:0]           s_tuser,  // command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fpa_pkg::WORD_W-1:0]          m_tdata,  // result
    output logic                                m_tuser   // divide_by_zero
);

    logic           f_valid;
    logic           f_ready;
    fpa_pkg::item_t f_item;
    logic           q_valid;
    logic           q_ready;
    fpa_pkg::item_t q_item;

    fpa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item)
    );

    fpa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    fpa_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
